/* hw/rtl/wsfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2812 frame encoder package
// Shared field widths, item codes, register indexes and the control/status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wsfe_pkg;

    // Field widths of the item, result and configuration channels.
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int COLOR_W  = 8;
    localparam int WORD_W   = 3 * COLOR_W;
    localparam int DUTY_W   = 10;
    localparam int SLOTS_W  = 8;
    localparam int LEDS_W   = 7;
    localparam int BIT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [KIND_W-1:0]     kind_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Item kinds.
    localparam kind_t KIND_SET   = 2'd0;
    localparam kind_t KIND_START = 2'd1;
    localparam kind_t KIND_TICK  = 2'd2;
    localparam kind_t KIND_NONE  = 2'd3;

    // Configuration register indexes.
    localparam cfg_idx_t REG_DUTY_ONE    = 2'd0;
    localparam cfg_idx_t REG_DUTY_ZERO   = 2'd1;
    localparam cfg_idx_t REG_RESET_SLOTS = 2'd2;
    localparam cfg_idx_t REG_LEDS_IN_USE = 2'd3;

    // Register reset values.
    localparam logic [DUTY_W-1:0]  DUTY_ONE_RST    = 10'd60;
    localparam logic [DUTY_W-1:0]  DUTY_ZERO_RST   = 10'd30;
    localparam logic [SLOTS_W-1:0] RESET_SLOTS_RST = 8'd50;
    localparam logic [LEDS_W-1:0]  LEDS_IN_USE_RST = 7'd64;

    // Most significant bit of a GRB word, where each LED starts.
    localparam logic [BIT_W-1:0] BIT_TOP = 5'd23;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;     // write black at the clear pointer and advance it
        logic store_write;    // write the item's colour to the frame store
        logic frame_start;    // rewind positions, read LED 0
        logic load_word;      // take the read word as the current LED
        logic bit_step;       // move to the next lower bit
        logic led_next;       // move to the next LED, take its prefetched word
        logic led_wrap;       // last LED done, rewind positions
        logic rst_step;       // count one reset slot
        logic rst_done;       // last reset slot done
        logic emit;           // load the result register
        logic emit_data;      // result duty comes from the current bit
        logic emit_in_frame;  // result belongs to a frame
        logic emit_last;      // result is the final period of the frame
    } wsfe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;     // clear pointer sits on the last entry
        logic index_ok;       // set item index is inside the store
        logic leds_nonzero;   // at least one LED is sent
        logic slots_nonzero;  // at least one reset slot is sent
        logic bit_zero;       // current bit is the last of the LED
        logic led_last;       // current LED is the last of the frame
        logic rst_last;       // current reset slot is the last one
    } wsfe_status_t;

endpackage

/* hw/rtl/wsfe_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2812 frame encoder channel interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------

// Request channel: set colour, start frame or bit-period tick.
interface wsfe_item_if;
    logic                           valid;
    logic                           ready;
    logic [wsfe_pkg::KIND_W-1:0]    kind;
    logic [wsfe_pkg::INDEX_W-1:0]   led_index;
    logic [wsfe_pkg::COLOR_W-1:0]   red;
    logic [wsfe_pkg::COLOR_W-1:0]   green;
    logic [wsfe_pkg::COLOR_W-1:0]   blue;

    modport source (output valid, kind, led_index, red, green, blue, input ready);
    modport sink   (input valid, kind, led_index, red, green, blue, output ready);
endinterface

// Result channel: one duty value per tick.
interface wsfe_result_if;
    logic                          valid;
    logic                          ready;
    logic [wsfe_pkg::DUTY_W-1:0]   duty;
    logic                          in_frame;
    logic                          frame_last;

    modport source (output valid, duty, in_frame, frame_last, input ready);
    modport sink   (input valid, duty, in_frame, frame_last, output ready);
endinterface

// Configuration write channel.
interface wsfe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wsfe_pkg::CFG_IDX_W-1:0]  index;
    logic [wsfe_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/wsfe_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wsfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/wsfe_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2812 frame encoder datapath
// Configuration registers, frame store, LED/bit/slot counters, current word
// and the result register. Acts only on commands from the controller and on configuration writes.
// ----------------------------------------------------------------------------
module wsfe_datapath #(
    parameter int LED_COUNT_MAX = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [wsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wsfe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [wsfe_pkg::INDEX_W-1:0]      led_index,
    input  logic [wsfe_pkg::COLOR_W-1:0]      red,
    input  logic [wsfe_pkg::COLOR_W-1:0]      green,
    input  logic [wsfe_pkg::COLOR_W-1:0]      blue,
    input  wsfe_pkg::wsfe_cmd_t               cmd,
    output wsfe_pkg::wsfe_status_t            status,
    output logic [wsfe_pkg::DUTY_W-1:0]       duty,
    output logic                              in_frame,
    output logic                              frame_last
);
    import wsfe_pkg::*;

    localparam int AW = (LED_COUNT_MAX > 1) ? $clog2(LED_COUNT_MAX) : 1;
    localparam int CW = ((AW > LEDS_W) ? AW : LEDS_W) + 1;

    // Configuration registers.
    logic [DUTY_W-1:0]  duty_one_reg;
    logic [DUTY_W-1:0]  duty_zero_reg;
    logic [SLOTS_W-1:0] reset_slots_reg;
    logic [LEDS_W-1:0]  leds_in_use_reg;

    // Sequencing state.
    logic [AW-1:0]      clear_cnt_reg, clear_cnt_next;
    logic [AW-1:0]      led_pos_reg, led_pos_next;
    logic [BIT_W-1:0]   bit_pos_reg, bit_pos_next;
    logic [SLOTS_W-1:0] rst_cnt_reg, rst_cnt_next;
    logic [WORD_W-1:0]  word_reg, word_next;

    // Result payload.
    logic [DUTY_W-1:0]  duty_reg;
    logic               in_frame_reg;
    logic               last_reg;
    logic [DUTY_W-1:0]  bit_duty;

    // Frame store access.
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [WORD_W-1:0]  ram_wr_data;
    logic [AW-1:0]      ram_rd_addr;
    logic [WORD_W-1:0]  ram_rd_data;
    logic [CW-1:0]      active_leds;

    // Configuration writes; the index covers exactly the four registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_one_reg    <= DUTY_ONE_RST;
            duty_zero_reg   <= DUTY_ZERO_RST;
            reset_slots_reg <= RESET_SLOTS_RST;
            leds_in_use_reg <= LEDS_IN_USE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DUTY_ONE:    duty_one_reg    <= cfg_data[DUTY_W-1:0];
                REG_DUTY_ZERO:   duty_zero_reg   <= cfg_data[DUTY_W-1:0];
                REG_RESET_SLOTS: reset_slots_reg <= cfg_data[SLOTS_W-1:0];
                REG_LEDS_IN_USE: leds_in_use_reg <= cfg_data[LEDS_W-1:0];
                default:         duty_one_reg    <= duty_one_reg;
            endcase
        end
    end

    // Number of LEDs sent, limited to the store depth.
    always_comb
    begin
        if (CW'(leds_in_use_reg) > CW'(LED_COUNT_MAX))
        begin
            active_leds = CW'(LED_COUNT_MAX);
        end
        else
        begin
            active_leds = CW'(leds_in_use_reg);
        end
    end

    // Counter and word updates.
    always_comb
    begin
        clear_cnt_next = clear_cnt_reg;
        led_pos_next   = led_pos_reg;
        bit_pos_next   = bit_pos_reg;
        rst_cnt_next   = rst_cnt_reg;
        word_next      = word_reg;

        if (cmd.clear_step)
        begin
            clear_cnt_next = clear_cnt_reg + AW'(1);
        end

        if (cmd.frame_start || cmd.led_wrap)
        begin
            led_pos_next = '0;
        end
        else if (cmd.led_next)
        begin
            led_pos_next = led_pos_reg + AW'(1);
        end

        if (cmd.frame_start || cmd.led_next || cmd.led_wrap)
        begin
            bit_pos_next = BIT_TOP;
        end
        else if (cmd.bit_step)
        begin
            bit_pos_next = bit_pos_reg - BIT_W'(1);
        end

        if (cmd.frame_start || cmd.led_wrap || cmd.rst_done)
        begin
            rst_cnt_next = '0;
        end
        else if (cmd.rst_step)
        begin
            rst_cnt_next = rst_cnt_reg + SLOTS_W'(1);
        end

        if (cmd.load_word || cmd.led_next)
        begin
            word_next = ram_rd_data;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            led_pos_reg   <= '0;
            bit_pos_reg   <= BIT_TOP;
            rst_cnt_reg   <= '0;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
            led_pos_reg   <= led_pos_next;
            bit_pos_reg   <= bit_pos_next;
            rst_cnt_reg   <= rst_cnt_next;
        end
    end

    // Current LED word and result payload.
    assign bit_duty = word_reg[bit_pos_reg] ? duty_one_reg : duty_zero_reg;

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (cmd.emit)
        begin
            duty_reg     <= cmd.emit_data ? bit_duty : '0;
            in_frame_reg <= cmd.emit_in_frame;
            last_reg     <= cmd.emit_last;
        end
    end

    // Frame store: the clearing pass writes black, set requests write GRB.
    // While a frame runs, the read port always fetches the next LED, so its
    // word is ready when the current LED's last bit goes out.
    assign ram_wr_en   = cmd.clear_step | cmd.store_write;
    assign ram_wr_addr = cmd.clear_step ? clear_cnt_reg : AW'(led_index);
    assign ram_wr_data = cmd.clear_step ? '0 : {green, red, blue};
    assign ram_rd_addr = cmd.frame_start ? '0 : (led_pos_reg + AW'(1));

    wsfe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LED_COUNT_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Status toward the controller.
    assign status.clear_done    = (clear_cnt_reg == AW'(LED_COUNT_MAX - 1));
    assign status.index_ok      = (32'(led_index) < LED_COUNT_MAX);
    assign status.leds_nonzero  = (leds_in_use_reg != '0);
    assign status.slots_nonzero = (reset_slots_reg != '0);
    assign status.bit_zero      = (bit_pos_reg == '0) || (bit_pos_reg > BIT_TOP);
    assign status.led_last      = ((CW'(led_pos_reg) + CW'(1)) >= active_leds);
    assign status.rst_last      = (({1'b0, rst_cnt_reg} + (SLOTS_W + 1)'(1))
                                   >= {1'b0, reset_slots_reg});

    assign duty       = duty_reg;
    assign in_frame   = in_frame_reg;
    assign frame_last = last_reg;

endmodule

/* hw/rtl/wsfe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2812 frame encoder controller
// Sequences store clearing, frame start, data bits and reset slots, and owns
// the request and result handshakes.
// ----------------------------------------------------------------------------
module wsfe_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [wsfe_pkg::KIND_W-1:0]  in_kind,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    input  wsfe_pkg::wsfe_status_t       status,
    output wsfe_pkg::wsfe_cmd_t          cmd
);
    import wsfe_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_RESET = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;
    logic       accept;
    logic       tick;

    // Requests are taken in the working states while the result slot is free
    // or being emptied in this cycle.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = ((state_reg == ST_IDLE) || (state_reg == ST_DATA)
                        || (state_reg == ST_RESET)) && slot_free;
    assign accept    = in_valid && in_ready;
    assign tick      = accept && (in_kind == KIND_TICK);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (in_kind == KIND_SET))
                begin
                    cmd.store_write = status.index_ok;
                end
                else if (accept && (in_kind == KIND_START))
                begin
                    cmd.frame_start = 1'b1;
                    if (status.leds_nonzero)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (status.slots_nonzero)
                    begin
                        state_next = ST_RESET;
                    end
                end
                else if (tick)
                begin
                    cmd.emit = 1'b1;
                end
            end
            ST_LOAD:
            begin
                cmd.load_word = 1'b1;
                state_next    = ST_DATA;
            end
            ST_DATA:
            begin
                if (tick)
                begin
                    cmd.emit          = 1'b1;
                    cmd.emit_data     = 1'b1;
                    cmd.emit_in_frame = 1'b1;
                    if (!status.bit_zero)
                    begin
                        cmd.bit_step = 1'b1;
                    end
                    else if (!status.led_last)
                    begin
                        cmd.led_next = 1'b1;
                    end
                    else
                    begin
                        cmd.led_wrap = 1'b1;
                        if (status.slots_nonzero)
                        begin
                            state_next = ST_RESET;
                        end
                        else
                        begin
                            cmd.emit_last = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end
            ST_RESET:
            begin
                if (tick)
                begin
                    cmd.emit          = 1'b1;
                    cmd.emit_in_frame = 1'b1;
                    if (status.rst_last)
                    begin
                        cmd.rst_done  = 1'b1;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rst_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Result slot occupancy.
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("result register overwritten while occupied");

    // Every accepted tick shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> out_valid_reg)
        else $error("accepted tick produced no result");

    // The word fetch after a start leads to the data phase in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_DATA))
        else $error("word load did not lead to the data phase");

    // The frame store is only written by a set request while no frame runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_write |-> ((state_reg == ST_IDLE) && accept && (in_kind == KIND_SET)))
        else $error("frame store written outside an idle set request");

    // The last period of a frame is always marked as part of the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_last) |-> (cmd.emit_in_frame && (state_next == ST_IDLE)))
        else $error("frame end flagged outside a frame");

endmodule

/* hw/rtl/ws2812_frame_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2812 frame encoder
// Frame store of GRB colors that turns bit-period ticks into PWM duty values.
// ----------------------------------------------------------------------------
// Usage:
//   items   - request channel. A set request writes one LED color (indexes at
//             or above LED_COUNT_MAX are dropped), a start request begins a
//             frame, a tick asks for the duty value of one bit period. Set and
//             start requests are dropped while a frame is being sent.
//   results - one result per tick: duty, in_frame and frame_last. Other
//             requests give no result.
//   cfg     - register writes (duty_one, duty_zero, reset_slots, leds_in_use),
//             always ready; write only while no frame is in progress.
// Timing: a request is taken each cycle while items.ready is high; a tick's
//   result appears in the result register in the cycle after it is accepted.
//   A start request that begins a frame with at least one LED is followed by
//   one cycle with ready low while LED 0 is read from the store.
//   The store's single read port prefetches the next LED during each LED.
// Reset: registers return to their defaults, then the store is cleared to
//   black, one entry per cycle until every entry is written, with ready low.
// Stall: while a result waits and results.ready is low, items.ready is low.
// ----------------------------------------------------------------------------
module ws2812_frame_encoder #(
    parameter int LED_COUNT_MAX = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    wsfe_item_if.sink      items,
    wsfe_result_if.source  results,
    wsfe_cfg_if.sink       cfg
);
    import wsfe_pkg::*;

    wsfe_cmd_t    cmd;
    wsfe_status_t status;

    // Configuration writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    // Controller: handshakes and sequencing.
    wsfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_kind   (items.kind),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: registers, frame store, counters and result payload.
    wsfe_datapath #(
        .LED_COUNT_MAX (LED_COUNT_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .led_index  (items.led_index),
        .red        (items.red),
        .green      (items.green),
        .blue       (items.blue),
        .cmd        (cmd),
        .status     (status),
        .duty       (results.duty),
        .in_frame   (results.in_frame),
        .frame_last (results.frame_last)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2812 frame encoder testbench
// Drives set, start and tick requests plus register writes into the encoder,
// predicts every duty period from a behavioral copy of the frame store and
// the send sequencer, and checks each result in order. Random gaps and
// stalls are applied on both channels.
// ----------------------------------------------------------------------------
module tb;

    import wsfe_pkg::*;

    localparam int STORE_DEPTH   = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_TARGET = 1350;

    typedef enum logic [1:0] {
        SEND_IDLE,
        SEND_DATA,
        SEND_RESET
    } send_phase_t;

    // One bit period as seen on the result channel.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              in_frame;
        logic              frame_last;
    } period_t;

    // Predicts the duty periods of the encoder and checks them in order.
    class duty_scoreboard;
        logic [DUTY_W-1:0]  duty_one_reg;
        logic [DUTY_W-1:0]  duty_zero_reg;
        logic [SLOTS_W-1:0] reset_slots_reg;
        logic [LEDS_W-1:0]  leds_in_use_reg;
        logic [WORD_W-1:0]  grb_store [STORE_DEPTH];
        int unsigned        led_pos;
        int unsigned        bit_pos;
        int unsigned        slot_count;
        send_phase_t        phase;
        period_t            expected_periods [$];
        int unsigned        errors;

        function new();
            duty_one_reg    = DUTY_ONE_RST;
            duty_zero_reg   = DUTY_ZERO_RST;
            reset_slots_reg = RESET_SLOTS_RST;
            leds_in_use_reg = LEDS_IN_USE_RST;
            foreach (grb_store[i])
                grb_store[i] = '0;
            led_pos    = 0;
            bit_pos    = BIT_TOP;
            slot_count = 0;
            phase      = SEND_IDLE;
            errors     = 0;
        endfunction

        function void write_reg(cfg_idx_t index, cfg_data_t data);
            case (index)
                REG_DUTY_ONE:    duty_one_reg    = data[DUTY_W-1:0];
                REG_DUTY_ZERO:   duty_zero_reg   = data[DUTY_W-1:0];
                REG_RESET_SLOTS: reset_slots_reg = data[SLOTS_W-1:0];
                REG_LEDS_IN_USE: leds_in_use_reg = data[LEDS_W-1:0];
                default: ;
            endcase
        endfunction

        // LED count of a frame, clamped to the store depth.
        function int unsigned active_leds();
            return (leds_in_use_reg > STORE_DEPTH) ? STORE_DEPTH : leds_in_use_reg;
        endfunction

        function bit busy();
            return phase != SEND_IDLE;
        endfunction

        function int unsigned pending();
            return expected_periods.size();
        endfunction

        // Update the model with an accepted request; a tick queues one period.
        function void note_request(kind_t kind, logic [INDEX_W-1:0] index,
                                   logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                                   logic [COLOR_W-1:0] blue);
            period_t           p;
            logic [WORD_W-1:0] word;
            p = '0;
            case (kind)
                KIND_SET:
                begin
                    if (phase == SEND_IDLE && index < STORE_DEPTH)
                        grb_store[index] = {green, red, blue};
                end
                KIND_START:
                begin
                    if (phase == SEND_IDLE)
                    begin
                        led_pos    = 0;
                        bit_pos    = BIT_TOP;
                        slot_count = 0;
                        if (active_leds() > 0)
                            phase = SEND_DATA;
                        else if (reset_slots_reg > 0)
                            phase = SEND_RESET;
                    end
                end
                KIND_TICK:
                begin
                    if (phase == SEND_DATA)
                    begin
                        word       = grb_store[led_pos % STORE_DEPTH];
                        p.duty     = word[bit_pos] ? duty_one_reg : duty_zero_reg;
                        p.in_frame = 1'b1;
                        if (bit_pos == 0)
                        begin
                            bit_pos = BIT_TOP;
                            if (led_pos + 1 >= active_leds())
                            begin
                                led_pos    = 0;
                                slot_count = 0;
                                if (reset_slots_reg > 0)
                                    phase = SEND_RESET;
                                else
                                begin
                                    p.frame_last = 1'b1;
                                    phase        = SEND_IDLE;
                                end
                            end
                            else
                                led_pos++;
                        end
                        else
                            bit_pos--;
                    end
                    else if (phase == SEND_RESET)
                    begin
                        p.in_frame = 1'b1;
                        if (slot_count + 1 >= reset_slots_reg)
                        begin
                            p.frame_last = 1'b1;
                            slot_count   = 0;
                            phase        = SEND_IDLE;
                        end
                        else
                            slot_count++;
                    end
                    expected_periods.push_back(p);
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result with the oldest expected period.
        function void check_period(period_t got);
            period_t want;
            if (expected_periods.size() == 0)
            begin
                $error("unexpected result: duty %0d, in_frame %0d, frame_last %0d",
                       got.duty, got.in_frame, got.frame_last);
                errors++;
                return;
            end
            want = expected_periods.pop_front();
            if (got.duty !== want.duty)
            begin
                $error("duty: expected %0d, actual %0d", want.duty, got.duty);
                errors++;
            end
            if (got.in_frame !== want.in_frame)
            begin
                $error("in_frame: expected %0d, actual %0d", want.in_frame, got.in_frame);
                errors++;
            end
            if (got.frame_last !== want.frame_last)
            begin
                $error("frame_last: expected %0d, actual %0d",
                       want.frame_last, got.frame_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count;
    int unsigned traffic_mode;
    int unsigned counted_requests;

    duty_scoreboard sb;

    wsfe_item_if   items_ch ();
    wsfe_result_if results_ch ();
    wsfe_cfg_if    cfg_ch ();

    ws2812_frame_encoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Cycle counter with a hard limit on the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result receiver: random stalls according to the traffic mode.
    always @(negedge clk)
    begin
        case (traffic_mode)
            0: results_ch.ready <= ($urandom_range(99) >= 59);
            1: results_ch.ready <= ($urandom_range(99) >= 24);
            default: results_ch.ready <= 1'b1;
        endcase
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
            sb.check_period({results_ch.duty, results_ch.in_frame, results_ch.frame_last});
    end

    // Present one request and wait until it is accepted.
    task automatic send_request(kind_t kind, logic [INDEX_W-1:0] index,
                                logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                                logic [COLOR_W-1:0] blue);
        int unsigned idle_pct;
        // Traffic pattern follows the progress through the request budget.
        traffic_mode = (counted_requests * 3) / RANDOM_TARGET;
        idle_pct = (traffic_mode == 0) ? 24 : (traffic_mode == 1) ? 59 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            items_ch.valid <= 1'b0;
        end
        @(negedge clk);
        items_ch.valid     <= 1'b1;
        items_ch.kind      <= kind;
        items_ch.led_index <= index;
        items_ch.red       <= red;
        items_ch.green     <= green;
        items_ch.blue      <= blue;
        do
            @(posedge clk);
        while (!items_ch.ready);
        // Unused kinds, and set or start requests while a frame runs, are not counted.
        if (kind == KIND_TICK || (kind != KIND_NONE && !sb.busy()))
            counted_requests++;
        sb.note_request(kind, index, red, green, blue);
    endtask

    // Request of the given kind with a random payload.
    task automatic send_kind(kind_t kind);
        send_request(kind, INDEX_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                     COLOR_W'($urandom));
    endtask

    task automatic write_reg(cfg_idx_t index, cfg_data_t data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Let every expected result arrive, then allow the pipeline to settle.
    task automatic wait_quiet();
        @(negedge clk);
        items_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Tick until the current frame is over, with ignored requests mixed in.
    task automatic finish_frame();
        int unsigned pick;
        while (sb.busy())
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_kind(KIND_SET);
            else if (pick < 6)
                send_kind(KIND_START);
            else if (pick < 8)
                send_kind(KIND_NONE);
            else
                send_kind(KIND_TICK);
        end
    endtask

    // One random configuration followed by a frame, mostly well formed.
    task automatic run_random_phase(bit long_frame, bit no_slots);
        int unsigned n_sets;
        int unsigned pick;
        int unsigned top;
        cfg_data_t   data;
        wait_quiet();
        // Duty registers: extremes or random.
        if (long_frame || $urandom_range(99) < 70)
        begin
            pick = $urandom_range(2);
            data = (pick == 0) ? '0 : (pick == 1) ? '1 : cfg_data_t'($urandom);
            write_reg(REG_DUTY_ONE, data);
        end
        if (long_frame || $urandom_range(99) < 70)
        begin
            pick = $urandom_range(2);
            data = (pick == 0) ? '0 : (pick == 1) ? '1 : cfg_data_t'($urandom);
            write_reg(REG_DUTY_ZERO, data);
        end
        // Reset slots: mostly short, sometimes none or the maximum.
        if (long_frame)
            write_reg(REG_RESET_SLOTS, {2'($urandom), 8'($urandom_range(1, 6))});
        else if (no_slots)
            write_reg(REG_RESET_SLOTS, {2'($urandom), 8'd0});
        else if ($urandom_range(99) < 70)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                data = {2'($urandom), 8'd0};
            else if (pick < 16)
                data = {2'($urandom), 8'd255};
            else if (pick < 24)
                data = {2'($urandom), 8'($urandom_range(7, 40))};
            else
                data = {2'($urandom), 8'($urandom_range(1, 6))};
            write_reg(REG_RESET_SLOTS, data);
        end
        // LED count: a full frame only for the long case, else a few LEDs.
        if (long_frame)
            write_reg(REG_LEDS_IN_USE, {3'($urandom), ($urandom_range(1) ? 7'd127 : 7'd64)});
        else if (no_slots || $urandom_range(99) < 70)
        begin
            pick = $urandom_range(99);
            if (pick < 10 && !no_slots)
                data = {3'($urandom), 7'd0};
            else if (pick < 85)
                data = {3'($urandom), 7'($urandom_range(1, 3))};
            else
                data = {3'($urandom), 7'($urandom_range(4, 6))};
            write_reg(REG_LEDS_IN_USE, data);
        end
        // Color writes, mostly inside the LEDs that are sent.
        n_sets = $urandom_range(0, 4);
        top    = (sb.active_leds() > 0) ? sb.active_leds() - 1 : 0;
        for (int i = 0; i < n_sets; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_request(KIND_SET, INDEX_W'($urandom_range(0, top)),
                             COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
            else
                send_kind(KIND_SET);
            pick = $urandom_range(99);
            if (pick < 10)
                send_kind(KIND_TICK);
            else if (pick < 15)
                send_kind(KIND_NONE);
        end
        // A broken sequence now and then: ticks without a start.
        if (!long_frame && $urandom_range(99) < 10)
        begin
            repeat ($urandom_range(1, 3)) send_kind(KIND_TICK);
            return;
        end
        send_kind(KIND_START);
        finish_frame();
        if ($urandom_range(99) < 20)
            send_kind(KIND_TICK);
    endtask

    // Main stimulus.
    initial
    begin
        bit long_done;
        int unsigned phase_count;

        rst_n              = 1'b0;
        cycle_count        = 0;
        traffic_mode       = 0;
        counted_requests   = 0;
        long_done          = 1'b0;
        phase_count        = 0;
        items_ch.valid     = 1'b0;
        items_ch.kind      = KIND_NONE;
        items_ch.led_index = '0;
        items_ch.red       = '0;
        items_ch.green     = '0;
        items_ch.blue      = '0;
        results_ch.ready   = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_DUTY_ONE;
        cfg_ch.data        = '0;
        sb = new();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle tick, unused kind and extreme colors.
        send_kind(KIND_TICK);
        send_kind(KIND_NONE);
        send_request(KIND_SET, 6'd63, 8'hFF, 8'hFF, 8'hFF);
        send_request(KIND_SET, 6'd0, 8'h00, 8'hFF, 8'h00);
        send_request(KIND_SET, 6'd1, 8'hFF, 8'h00, 8'h00);
        send_request(KIND_SET, 6'd2, 8'h00, 8'h00, 8'hFF);

        // Directed: empty frame, where a start does nothing.
        wait_quiet();
        write_reg(REG_DUTY_ONE, 10'd1023);
        write_reg(REG_DUTY_ZERO, 10'd0);
        write_reg(REG_RESET_SLOTS, 10'd0);
        write_reg(REG_LEDS_IN_USE, 10'd0);
        send_kind(KIND_START);
        send_kind(KIND_TICK);

        // Directed: no LEDs, one reset slot; set and start while busy.
        wait_quiet();
        write_reg(REG_RESET_SLOTS, 10'd1);
        send_kind(KIND_START);
        send_request(KIND_SET, 6'd0, 8'h5A, 8'hA5, 8'h3C);
        send_kind(KIND_START);
        send_kind(KIND_NONE);
        send_kind(KIND_TICK);
        send_kind(KIND_TICK);

        // Random phases; the first one has no reset slots and mostly ends a data frame.
        // The full-length frame counts toward the request budget.
        while (counted_requests < RANDOM_TARGET)
        begin
            if (!long_done && counted_requests >= 250)
            begin
                run_random_phase(1'b1, 1'b0);
                long_done = 1'b1;
            end
            else
                run_random_phase(1'b0, phase_count == 0);
            phase_count++;
        end

        // Drain and report.
        wait_quiet();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
